/* rtl/gas_pkg.sv */
package gas_pkg;

   // Grid geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_SIDE   = 3;

   // Field and register widths
   localparam int CELL_BITS = 2;
   localparam int GW_BITS   = 11;
   localparam int GH_BITS   = 13;
   localparam int THR_BITS  = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_BITS  = 2;
   localparam int CSR_ADDR_BITS = REG_BITS + 2;

   // Position counters
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT + 2);
   localparam int OROW_BITS = $clog2(MAX_HEIGHT);
   localparam int WCMP_BITS = (COL_BITS + 1 > GW_BITS) ? COL_BITS + 1 : GW_BITS;
   localparam int HCMP_BITS = (ROW_BITS > GH_BITS) ? ROW_BITS : GH_BITS;
   localparam int WALL_BITS = 4;

   // Result queue
   localparam int OUTQ_DEPTH = 3;
   localparam int QPTR_BITS  = $clog2(OUTQ_DEPTH);
   localparam int QCNT_BITS  = $clog2(OUTQ_DEPTH + 1);

   // Reset values
   localparam logic [GW_BITS-1:0]  RST_GRID_WIDTH  = GW_BITS'(64);
   localparam logic [GH_BITS-1:0]  RST_GRID_HEIGHT = GH_BITS'(64);
   localparam logic [THR_BITS-1:0] RST_OPEN_THR    = THR_BITS'(4);
   localparam logic [THR_BITS-1:0] RST_CLOSE_THR   = THR_BITS'(7);

   // Cell codes and opcodes
   localparam logic [CELL_BITS-1:0] CELL_WALL   = CELL_BITS'(0);
   localparam logic [CELL_BITS-1:0] CELL_OPENED = CELL_BITS'(2);
   localparam logic OP_CELL  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef enum logic [REG_BITS-1:0] {
      REG_GRID_WIDTH  = 2'd0,
      REG_GRID_HEIGHT = 2'd1,
      REG_OPEN_THR    = 2'd2,
      REG_CLOSE_THR   = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [GW_BITS-1:0]  grid_width;
      logic [GH_BITS-1:0]  grid_height;
      logic [THR_BITS-1:0] open_thr;
      logic [THR_BITS-1:0] close_thr;
   } cfg_type;

   // One advancing beat, handed from the scan counters to the window stage
   typedef struct packed {
      logic                 valid;
      logic [COL_BITS-1:0]  col;
      logic [CELL_BITS-1:0] val;
      logic                 prod;
      logic                 interior;
      logic                 last;
   } stage_type;

   typedef struct packed {
      logic [CELL_BITS-1:0] cell_value;
      logic                 last;
   } out_type;

   typedef logic [2:0][2:0][CELL_BITS-1:0] window_type;

   function automatic logic [GW_BITS-1:0] eff_width(input logic [GW_BITS-1:0] w);
      logic [GW_BITS-1:0] r;
      r = w;
      if (int'(w) < MIN_SIDE) r = GW_BITS'(MIN_SIDE);
      else if (int'(w) > MAX_WIDTH) r = GW_BITS'(MAX_WIDTH);
      return r;
   endfunction

   function automatic logic [GH_BITS-1:0] eff_height(input logic [GH_BITS-1:0] h);
      logic [GH_BITS-1:0] r;
      r = h;
      if (int'(h) < MIN_SIDE) r = GH_BITS'(MIN_SIDE);
      else if (int'(h) > MAX_HEIGHT) r = GH_BITS'(MAX_HEIGHT);
      return r;
   endfunction

endpackage

/* rtl/gas_ram.sv */
module gas_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gas_csr.sv */
module gas_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gas_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [gas_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [gas_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output gas_pkg::cfg_type                     cfg,
   output logic                                 restart
);

   gas_pkg::cfg_type     cfg_ff, cfg_in;
   gas_pkg::csr_reg_type idx;
   logic                 wr;

   assign idx = gas_pkg::csr_reg_type'(csr_paddr[gas_pkg::CSR_ADDR_BITS-1:2]);
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (wr) begin
         case (idx)
            gas_pkg::REG_GRID_WIDTH: begin
               cfg_in.grid_width = csr_pwdata[gas_pkg::GW_BITS-1:0];
               restart = 1'b1;
            end
            gas_pkg::REG_GRID_HEIGHT: begin
               cfg_in.grid_height = csr_pwdata[gas_pkg::GH_BITS-1:0];
               restart = 1'b1;
            end
            gas_pkg::REG_OPEN_THR: begin
               cfg_in.open_thr = csr_pwdata[gas_pkg::THR_BITS-1:0];
            end
            gas_pkg::REG_CLOSE_THR: begin
               cfg_in.close_thr = csr_pwdata[gas_pkg::THR_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         gas_pkg::REG_GRID_WIDTH:
            csr_prdata = gas_pkg::CSR_DATA_BITS'(cfg_ff.grid_width);
         gas_pkg::REG_GRID_HEIGHT:
            csr_prdata = gas_pkg::CSR_DATA_BITS'(cfg_ff.grid_height);
         gas_pkg::REG_OPEN_THR:
            csr_prdata = gas_pkg::CSR_DATA_BITS'(cfg_ff.open_thr);
         gas_pkg::REG_CLOSE_THR:
            csr_prdata = gas_pkg::CSR_DATA_BITS'(cfg_ff.close_thr);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= gas_pkg::RST_GRID_WIDTH;
         cfg_ff.grid_height <= gas_pkg::RST_GRID_HEIGHT;
         cfg_ff.open_thr    <= gas_pkg::RST_OPEN_THR;
         cfg_ff.close_thr   <= gas_pkg::RST_CLOSE_THR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg        = cfg_ff;
   assign csr_pready = 1'b1;

endmodule

/* rtl/gas_scan.sv */
module gas_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                restart,
   input  gas_pkg::cfg_type                    cfg,
   input  logic                                space,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [gas_pkg::CELL_BITS-1:0]       req_cell_in,
   output logic                                rd_en,
   output logic [gas_pkg::COL_BITS-1:0]        rd_addr,
   output gas_pkg::stage_type                  stage
);

   localparam int WC = gas_pkg::WCMP_BITS;
   localparam int HC = gas_pkg::HCMP_BITS;

   logic [gas_pkg::COL_BITS-1:0]  in_col_ff, in_col_in;
   logic [gas_pkg::ROW_BITS-1:0]  in_row_ff, in_row_in;
   logic [gas_pkg::COL_BITS-1:0]  out_col_ff, out_col_in;
   logic [gas_pkg::OROW_BITS-1:0] out_row_ff, out_row_in;
   gas_pkg::stage_type            stage_ff, stage_in;

   logic [gas_pkg::GW_BITS-1:0] w;
   logic [gas_pkg::GH_BITS-1:0] h;
   logic [WC-1:0] wx;
   logic [HC-1:0] hx;
   logic accept, in_frame, advance, col_wrap, out_wrap;
   logic prod, interior, last;
   logic [gas_pkg::CELL_BITS-1:0] val;

   assign w  = gas_pkg::eff_width(cfg.grid_width);
   assign h  = gas_pkg::eff_height(cfg.grid_height);
   assign wx = WC'(w);
   assign hx = HC'(h);

   assign req_ready = space;
   assign accept    = req_valid && space;
   assign in_frame  = HC'(in_row_ff) < hx;
   // a flush inside the grid is dropped; past the grid every beat drains
   assign advance   = accept && !(in_frame && req_opcode == gas_pkg::OP_FLUSH);
   assign val       = in_frame ? req_cell_in : gas_pkg::CELL_WALL;

   assign col_wrap = (WC'(in_col_ff) + WC'(1)) == wx;
   assign out_wrap = (WC'(out_col_ff) + WC'(1)) == wx;

   // first width+1 slots only fill the window
   assign prod = !(in_row_ff == '0 ||
                   (in_row_ff == gas_pkg::ROW_BITS'(1) && in_col_ff == '0));
   assign interior = (out_row_ff != '0) && (HC'(out_row_ff) + HC'(2) <= hx) &&
                     (out_col_ff != '0) && (WC'(out_col_ff) + WC'(2) <= wx);
   assign last = (HC'(out_row_ff) + HC'(1) == hx) && out_wrap;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart || (advance && prod && last)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (advance) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + gas_pkg::ROW_BITS'(1);
         end else begin
            in_col_in = in_col_ff + gas_pkg::COL_BITS'(1);
         end
         if (prod) begin
            if (out_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_ff + gas_pkg::OROW_BITS'(1);
            end else begin
               out_col_in = out_col_ff + gas_pkg::COL_BITS'(1);
            end
         end
      end
   end

   always_comb begin
      stage_in.valid    = advance && !restart;
      stage_in.col      = in_col_ff;
      stage_in.val      = val;
      stage_in.prod     = prod;
      stage_in.interior = interior;
      stage_in.last     = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         stage_ff   <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         stage_ff   <= stage_in;
      end
   end

   assign rd_en   = advance;
   assign rd_addr = in_col_ff;
   assign stage   = stage_ff;

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (stage_ff.valid && stage_ff.prod && stage_ff.last) |->
      (in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("frame position not cleared after final cell");

   a_flush_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && in_frame && req_opcode == gas_pkg::OP_FLUSH) |=> !stage_ff.valid)
      else $error("flush inside the grid advanced the scan");

endmodule

/* rtl/gas_window.sv */
module gas_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  logic [gas_pkg::THR_BITS-1:0]      open_thr,
   input  logic [gas_pkg::THR_BITS-1:0]      close_thr,
   input  logic                              rd_en,
   input  logic [gas_pkg::COL_BITS-1:0]      rd_addr,
   input  gas_pkg::stage_type                stage,
   output logic                              push,
   output gas_pkg::out_type                  push_data
);

   localparam int CB = gas_pkg::CELL_BITS;

   gas_pkg::window_type win_ff, win_in, win_sh;
   logic [2*CB-1:0]     rd_data;
   logic [2*CB-1:0]     wr_data;
   logic [gas_pkg::WALL_BITS-1:0] walls;
   logic [CB-1:0]       centre;
   logic [CB-1:0]       result;

   // one word per column: {row two back, row one back}
   gas_ram #(
      .WIDTH (2 * CB),
      .DEPTH (gas_pkg::MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (stage.valid),
      .wr_addr (stage.col),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_data = {rd_data[CB-1:0], stage.val};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_sh[r][0] = win_ff[r][1];
         win_sh[r][1] = win_ff[r][2];
      end
      win_sh[0][2] = rd_data[2*CB-1:CB];
      win_sh[1][2] = rd_data[CB-1:0];
      win_sh[2][2] = stage.val;
   end

   always_comb begin
      walls = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            walls = walls + gas_pkg::WALL_BITS'(win_sh[r][c] == gas_pkg::CELL_WALL);
         end
      end
   end

   assign centre = win_sh[1][1];

   always_comb begin
      result = centre;
      if (stage.interior) begin
         if (centre == gas_pkg::CELL_WALL && walls < open_thr) begin
            result = gas_pkg::CELL_OPENED;
         end else if (centre != gas_pkg::CELL_WALL && walls >= close_thr) begin
            result = gas_pkg::CELL_WALL;
         end
      end
   end

   always_comb begin
      win_in = win_ff;
      if (restart) begin
         win_in = '0;
      end else if (stage.valid) begin
         win_in = (stage.prod && stage.last) ? '0 : win_sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   assign push                 = stage.valid && stage.prod;
   assign push_data.cell_value = result;
   assign push_data.last       = stage.last;

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      restart |-> !stage.valid)
      else $error("geometry write while a beat is in the window stage");

endmodule

/* rtl/gas_outq.sv */
module gas_outq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  gas_pkg::out_type                push_data,
   input  logic                            pop,
   output logic                            out_valid,
   output gas_pkg::out_type                out_data,
   output logic [gas_pkg::QCNT_BITS-1:0]   count
);

   localparam int DEPTH = gas_pkg::OUTQ_DEPTH;

   gas_pkg::out_type                  slot_ff [DEPTH];
   logic [gas_pkg::QPTR_BITS-1:0]     head_ff, head_in;
   logic [gas_pkg::QPTR_BITS-1:0]     tail_ff, tail_in;
   logic [gas_pkg::QCNT_BITS-1:0]     count_ff, count_in;
   logic                              do_pop;

   function automatic logic [gas_pkg::QPTR_BITS-1:0] bump(
      input logic [gas_pkg::QPTR_BITS-1:0] p);
      logic [gas_pkg::QPTR_BITS-1:0] n;
      n = (int'(p) == DEPTH - 1) ? '0 : p + gas_pkg::QPTR_BITS'(1);
      return n;
   endfunction

   assign out_valid = count_ff != '0;
   assign do_pop    = pop && out_valid;
   assign out_data  = slot_ff[head_ff];
   assign count     = count_ff;

   always_comb begin
      head_in  = do_pop ? bump(head_ff) : head_ff;
      tail_in  = push ? bump(tail_ff) : tail_ff;
      count_in = count_ff + gas_pkg::QCNT_BITS'(push) - gas_pkg::QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != gas_pkg::QCNT_BITS'(DEPTH) || pop))
      else $error("result pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= DEPTH)
      else $error("result queue count out of range");

endmodule

/* rtl/grid_3x3_automaton_smoother.sv */
// channel  | handshake               | payload
// req      | req_valid / req_ready   | req_opcode, req_cell_in
// rsp      | rsp_valid / rsp_ready   | rsp_cell_out, rsp_frame_last
// csr      | csr_psel/penable/pready | csr_paddr, csr_pwrite, csr_pwdata, csr_prdata
//
// One beat per cycle while req_ready is high; the line RAM is read at the edge that takes a
// beat and written back in the next cycle, when the result enters the queue, so rsp_valid
// is high once the queue holds that result.
// A result lags its cell by width+1 beats; flush beats after the grid drain it.
// req_ready drops only when the three-entry result queue could fill.
// Synchronous reset clears positions, window and queue; the line RAM is not cleared.
module grid_3x3_automaton_smoother (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_opcode,
   input  logic [gas_pkg::CELL_BITS-1:0]        req_cell_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [gas_pkg::CELL_BITS-1:0]        rsp_cell_out,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gas_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [gas_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [gas_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   gas_pkg::cfg_type              cfg;
   gas_pkg::stage_type            stage;
   gas_pkg::out_type              push_data;
   gas_pkg::out_type              out_data;
   logic                          restart;
   logic                          space;
   logic                          rd_en;
   logic [gas_pkg::COL_BITS-1:0]  rd_addr;
   logic                          push;
   logic [gas_pkg::QCNT_BITS-1:0] q_count;

   // room for everything in flight plus one more beat
   assign space = (gas_pkg::QCNT_BITS'(q_count) + gas_pkg::QCNT_BITS'(stage.valid && stage.prod))
                  < gas_pkg::QCNT_BITS'(gas_pkg::OUTQ_DEPTH);

   gas_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .restart     (restart)
   );

   gas_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .cfg         (cfg),
      .space       (space),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_cell_in (req_cell_in),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .stage       (stage)
   );

   gas_window u_window (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .open_thr  (cfg.open_thr),
      .close_thr (cfg.close_thr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .stage     (stage),
      .push      (push),
      .push_data (push_data)
   );

   gas_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .count     (q_count)
   );

   assign rsp_cell_out   = out_data.cell_value;
   assign rsp_frame_last = out_data.last;

endmodule
